FILE: rtl/labelwise_newton_score_eval_macros.svh
// Assertion macros shared by the evaluator.
`ifndef LABELWISE_NEWTON_SCORE_EVAL_MACROS_SVH
`define LABELWISE_NEWTON_SCORE_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define LNSE_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define LNSE_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LNSE_ASSERT_IMP(label, ck, rs, ante, cons)
`define LNSE_ASSERT_NXT(label, ck, rs, ante, cons)
`endif
`endif

FILE: rtl/lnse_pkg.sv
package lnse_pkg;

  localparam int IN_W  = 32;
  localparam int L2_W  = 32;
  localparam int G_W   = 33;
  localparam int D_W   = 35;
  localparam int GM_W  = 33;
  localparam int DM_W  = 34;
  localparam int S_W   = 32;
  localparam int Q_W   = 48;
  localparam int A_W   = 64;

  // Byte address of the L2 weight register on the configuration port.
  localparam logic [2:0] ADDR_L2_WEIGHT = 3'd0;

  localparam logic [S_W-1:0] S_MIN = {1'b1, {(S_W-1){1'b0}}};
  localparam logic [S_W-1:0] S_MAX = {1'b0, {(S_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [A_W-1:0] A_MIN = {1'b1, {(A_W-1){1'b0}}};
  localparam logic [A_W-1:0] A_MAX = {1'b0, {(A_W-1){1'b1}}};

  // One classified label, as handed from the front end to the back end.
  typedef struct packed {
    logic [G_W-1:0]  g;
    logic [D_W-1:0]  d;
    logic [GM_W-1:0] g_mag;
    logic [DM_W-1:0] d_mag;
    logic            d_zero;
    logic            last;
  } lnse_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lnse_fifo_stat_t;

endpackage

FILE: rtl/lnse_front.sv
module lnse_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lnse_pkg::IN_W-1:0]     grad_sum,
  input  logic [lnse_pkg::IN_W-1:0]     hess_sum,
  input  logic [lnse_pkg::IN_W-1:0]     total_grad,
  input  logic [lnse_pkg::IN_W-1:0]     total_hess,
  input  logic                          use_complement,
  input  logic                          last_label,
  input  logic [lnse_pkg::L2_W-1:0]     l2_weight,
  input  lnse_pkg::lnse_fifo_stat_t     fifo_stat,
  output logic                          push,
  output lnse_pkg::lnse_job_t           job
);
  import lnse_pkg::*;

  logic           held;
  logic           load;
  logic [G_W-1:0] g_r;
  logic [D_W-1:0] d_r;
  logic           last_r;
  logic [G_W-1:0] g_in;
  logic [G_W-1:0] h_in;
  logic [D_W-1:0] d_in;
  logic [G_W-1:0] g_neg;
  logic [D_W-1:0] d_neg;

  assign push     = held && !fifo_stat.full;
  assign in_stall = held && fifo_stat.full;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (use_complement) begin
      g_in = {total_grad[IN_W-1], total_grad} - {grad_sum[IN_W-1], grad_sum};
      h_in = {total_hess[IN_W-1], total_hess} - {hess_sum[IN_W-1], hess_sum};
    end else begin
      g_in = {grad_sum[IN_W-1], grad_sum};
      h_in = {hess_sum[IN_W-1], hess_sum};
    end
    d_in = {{(D_W-G_W){h_in[G_W-1]}}, h_in} + {{(D_W-L2_W){1'b0}}, l2_weight};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      g_r    <= g_in;
      d_r    <= d_in;
      last_r <= last_label;
    end
  end

  // The most negative g wraps to itself, which read unsigned is its magnitude.
  always_comb begin
    g_neg      = ~g_r + G_W'(1);
    d_neg      = ~d_r + D_W'(1);
    job.g      = g_r;
    job.d      = d_r;
    job.g_mag  = g_r[G_W-1] ? g_neg : g_r;
    job.d_mag  = d_r[D_W-1] ? d_neg[DM_W-1:0] : d_r[DM_W-1:0];
    job.d_zero = (d_r == '0);
    job.last   = last_r;
  end

endmodule

FILE: rtl/lnse_fifo.sv
module lnse_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  lnse_pkg::lnse_job_t       din,
  input  logic                      pop,
  output lnse_pkg::lnse_job_t       dout,
  output lnse_pkg::lnse_fifo_stat_t stat
);
  import lnse_pkg::*;

  localparam int DEPTH = 2;

  lnse_job_t  slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == 2'(DEPTH));
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/lnse_back.sv
module lnse_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lnse_pkg::lnse_fifo_stat_t       fifo_stat,
  input  lnse_pkg::lnse_job_t             head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [lnse_pkg::S_W-1:0] score,
  output logic signed [lnse_pkg::Q_W-1:0] quality,
  output logic signed [lnse_pkg::A_W-1:0] overall_quality,
  output logic                            is_last
);
  import lnse_pkg::*;

  localparam int NUMW = GM_W + FRAC_BITS;
  localparam int CMPW = DM_W + S_W;
  localparam int REMW = DM_W + 1;
  localparam int SS_W = 2 * S_W - 1;
  localparam int MA_W = 36;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;
  localparam int SUMW = 100;
  localparam int SH_LO = 2 * FRAC_BITS + 1;
  localparam int SHW = SUMW - SH_LO;
  localparam logic [4:0] CNT_LAST = 5'(S_W - 1);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_LOAD = 11'b000_0000_0010,
    ST_DIV  = 11'b000_0000_0100,
    ST_SIGN = 11'b000_0000_1000,
    ST_SQR  = 11'b000_0001_0000,
    ST_MGS  = 11'b000_0010_0000,
    ST_MLO  = 11'b000_0100_0000,
    ST_MHI  = 11'b000_1000_0000,
    ST_MADD = 11'b001_0000_0000,
    ST_QSAT = 11'b010_0000_0000,
    ST_ACC  = 11'b100_0000_0000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  lnse_job_t              cur;
  logic [REMW-1:0]        rem;
  logic [S_W-1:0]         div_lo;
  logic [S_W-1:0]         quo;
  logic [4:0]             cnt;
  logic [S_W-1:0]         s;
  logic [SS_W-1:0]        ss;
  logic signed [MP_W-1:0] prod;
  logic [SUMW-1:0]        sum;
  logic [Q_W-1:0]         q;
  logic [A_W-1:0]         acc;
  logic                   out_load;

  logic [NUMW-1:0]        num;
  logic                   ovf;
  logic                   res_neg;
  logic [REMW-1:0]        rem_sh;
  logic [REMW-1:0]        d_ext;
  logic                   rem_ge;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  logic [SUMW-1:0]        prod_ext;
  logic [SHW-1:0]         sh;
  logic                   q_fits;
  logic [A_W:0]           acc_sum;
  logic [A_W-1:0]         acc_new;

  assign num     = {cur.g_mag, {FRAC_BITS{1'b0}}};
  // A quotient of 2^32 or more saturates whatever the sign.
  assign ovf     = {{(CMPW-NUMW){1'b0}}, num} >= {cur.d_mag, {S_W{1'b0}}};
  assign res_neg = (cur.g[G_W-1] == cur.d[D_W-1]);
  assign rem_sh  = {rem[REMW-2:0], div_lo[S_W-1]};
  assign d_ext   = {1'b0, cur.d_mag};
  assign rem_ge  = (rem_sh >= d_ext);

  always_comb begin
    mul_a = {{(MA_W-S_W){s[S_W-1]}}, s};
    mul_b = {{(MB_W-S_W){s[S_W-1]}}, s};
    case (state)
      ST_MGS: begin
        mul_a = {{(MA_W-G_W){cur.g[G_W-1]}}, cur.g};
      end
      ST_MLO: begin
        mul_a = {{(MA_W-D_W){cur.d[D_W-1]}}, cur.d};
        mul_b = {1'b0, ss[S_W-1:0]};
      end
      ST_MHI: begin
        mul_a = {{(MA_W-D_W){cur.d[D_W-1]}}, cur.d};
        mul_b = {2'b00, ss[SS_W-1:S_W]};
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(SUMW-MP_W){prod[MP_W-1]}}, prod};

  assign sh     = sum[SUMW-1:SH_LO];
  assign q_fits = (&sh[SHW-1:Q_W-1]) || !(|sh[SHW-1:Q_W-1]);

  always_comb begin
    acc_sum = {acc[A_W-1], acc} + {{(A_W+1-Q_W){q[Q_W-1]}}, q};
    if (acc_sum[A_W] != acc_sum[A_W-1]) begin
      acc_new = acc_sum[A_W] ? A_MIN : A_MAX;
    end else begin
      acc_new = acc_sum[A_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop        = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = (cur.d_zero || ovf) ? ST_SQR : ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: state_next = ST_SQR;
      ST_SQR:  state_next = ST_MGS;
      ST_MGS:  state_next = ST_MLO;
      ST_MLO:  state_next = ST_MHI;
      ST_MHI:  state_next = ST_MADD;
      ST_MADD: state_next = ST_QSAT;
      ST_QSAT: state_next = ST_ACC;
      ST_ACC: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        acc       <= cur.last ? '0 : acc_new;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The remainder starts from the numerator bits above the low word; the
  // overflow check guarantees it is already below the divisor.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          cur <= head;
        end
      end
      ST_LOAD: begin
        rem    <= REMW'(num[NUMW-1:S_W]);
        div_lo <= num[S_W-1:0];
        quo    <= '0;
        cnt    <= '0;
        if (cur.d_zero) begin
          s <= '0;
        end else if (ovf) begin
          s <= res_neg ? S_MIN : S_MAX;
        end
      end
      ST_DIV: begin
        rem    <= rem_ge ? (rem_sh - d_ext) : rem_sh;
        quo    <= {quo[S_W-2:0], rem_ge};
        div_lo <= {div_lo[S_W-2:0], 1'b0};
        cnt    <= cnt + 5'd1;
      end
      ST_SIGN: begin
        if (res_neg) begin
          s <= (quo > S_MIN) ? S_MIN : (~quo + S_W'(1));
        end else begin
          s <= (quo > S_MAX) ? S_MAX : quo;
        end
      end
      ST_SQR: begin
        prod <= mul_p;
      end
      ST_MGS: begin
        ss   <= prod[SS_W-1:0];
        prod <= mul_p;
      end
      ST_MLO: begin
        sum  <= prod_ext << (FRAC_BITS + 1);
        prod <= mul_p;
      end
      ST_MHI: begin
        sum  <= sum + prod_ext;
        prod <= mul_p;
      end
      ST_MADD: begin
        sum <= sum + (prod_ext << S_W);
      end
      ST_QSAT: begin
        if (q_fits) begin
          q <= sh[Q_W-1:0];
        end else begin
          q <= sh[SHW-1] ? Q_MIN : Q_MAX;
        end
      end
      ST_ACC: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      score           <= s;
      quality         <= q;
      overall_quality <= cur.last ? acc_new : '0;
      is_last         <= cur.last;
    end
  end

endmodule

FILE: rtl/labelwise_newton_score_eval.sv
// The back end works on one item at a time, through its setup, the 32 steps of the
// radix-2 divider, four multiplier passes and the saturating accumulate; the divide
// is skipped when the denominator is zero or the quotient would be 2^32 or more.
// The front end register and the two-entry queue accept further items meanwhile.
// Reset (synchronous, active high) empties the queue, clears the accumulator and
// output valid, and sets l2_weight to 1.0.
`include "labelwise_newton_score_eval_macros.svh"

module labelwise_newton_score_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [lnse_pkg::IN_W-1:0] grad_sum,
  input  logic signed [lnse_pkg::IN_W-1:0] hess_sum,
  input  logic signed [lnse_pkg::IN_W-1:0] total_grad,
  input  logic signed [lnse_pkg::IN_W-1:0] total_hess,
  input  logic                            use_complement,
  input  logic                            last_label,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [lnse_pkg::S_W-1:0] score,
  output logic signed [lnse_pkg::Q_W-1:0] quality,
  output logic signed [lnse_pkg::A_W-1:0] overall_quality,
  output logic                            is_last
);
  import lnse_pkg::*;

  logic [L2_W-1:0] l2_weight;
  logic            fifo_push;
  logic            fifo_pop;
  lnse_job_t       front_job;
  lnse_job_t       fifo_head;
  lnse_fifo_stat_t fifo_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_L2_WEIGHT[2]) ? l2_weight : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_weight <= L2_W'(1) << FRAC_BITS;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_L2_WEIGHT[2])) begin
      l2_weight <= pwdata;
    end
  end

  lnse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .grad_sum       (grad_sum),
    .hess_sum       (hess_sum),
    .total_grad     (total_grad),
    .total_hess     (total_hess),
    .use_complement (use_complement),
    .last_label     (last_label),
    .l2_weight      (l2_weight),
    .fifo_stat      (fifo_stat),
    .push           (fifo_push),
    .job            (front_job)
  );

  lnse_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (fifo_push),
    .din  (front_job),
    .pop  (fifo_pop),
    .dout (fifo_head),
    .stat (fifo_stat)
  );

  lnse_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .fifo_stat       (fifo_stat),
    .head            (fifo_head),
    .pop             (fifo_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .score           (score),
    .quality         (quality),
    .overall_quality (overall_quality),
    .is_last         (is_last)
  );

  `LNSE_ASSERT_IMP(a_push_not_full, clk, rst, fifo_push, !fifo_stat.full)
  `LNSE_ASSERT_IMP(a_pop_not_empty, clk, rst, fifo_pop, !fifo_stat.empty)
  `LNSE_ASSERT_NXT(a_one_job_at_a_time, clk, rst, fifo_pop, !fifo_pop)

endmodule
